>>> design/ktp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package ktp_pkg;

  localparam int NODES_DEF  = 1024;
  localparam int LEVELS_DEF = 10;

  typedef logic [9:0]  node_t;
  typedef logic [3:0]  lvl_t;
  typedef logic [10:0] step_t;

  localparam node_t DEPTH_MAX = 10'd1023;

  // action codes of an input transaction
  localparam logic ACT_LOAD  = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  typedef struct packed {
    logic  action;
    node_t node;
    node_t parent_node;
    node_t target_node;
    step_t step;
  } in_item_t;

  typedef struct packed {
    logic  found;
    node_t result_node;
  } out_item_t;

  // table access request from the sequencer
  typedef struct packed {
    logic  dep_we;
    node_t dep_wnode;
    node_t dep_wdata;
    node_t dep_rnode;
    logic  anc_we;
    node_t anc_wnode;
    lvl_t  anc_wlvl;
    node_t anc_wdata;
    node_t anc_anode;
    lvl_t  anc_alvl;
    node_t anc_bnode;
    lvl_t  anc_blvl;
  } mem_req_t;

  // registered read data, valid in the cycle after the request
  typedef struct packed {
    node_t dep_rdata;
    node_t anc_adata;
    node_t anc_bdata;
  } mem_rsp_t;

endpackage
`default_nettype wire

>>> design/kth_node_on_tree_path_core.sv
// kth node on a tree path, binary lifting over a depth table and an ancestor table
//
// in_*: valid/ready input channel, one transaction per load or query.
//   load  (action 0): stores node with its parent; parents must be loaded first.
//   query (action 1): returns the step-th node on the path node -> target_node.
// out_*: valid/ready result channel, one transaction per query, none per load.
//
// one transaction is worked on at a time. a load does one depth read, then one
// ancestor read and write per level. a query does depth reads and hand-off, two
// climbs and, when the aligned endpoints differ, an lca search; each climb and
// search step waits on a registered read through the ancestor memory. a query
// with a bad endpoint or step 0 answers without climbing; a load of node 0 is
// taken and dropped without a table write.
//
// reset clears the sequencer and the result valid flag only; table contents are
// undefined until loaded, except node 0 which always reads as zero.
// a finished result sits in the output register; the next transaction is taken
// while it waits, and a later result holds until the receiver takes it.
`timescale 1ns / 1ps
`default_nettype none
module kth_node_on_tree_path_core #(
  parameter int NODES  = ktp_pkg::NODES_DEF,
  parameter int LEVELS = ktp_pkg::LEVELS_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire ktp_pkg::in_item_t   in_data,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output ktp_pkg::out_item_t       out_data
);
  import ktp_pkg::*;

  mem_req_t req;
  mem_rsp_t rsp;

  // sequencer
  ktp_ctrl #(.NODES(NODES), .LEVELS(LEVELS)) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .req       (req),
    .rsp       (rsp)
  );

  // depth and ancestor tables
  ktp_mem #(.NODES(NODES), .LEVELS(LEVELS)) u_mem (
    .clk (clk),
    .req (req),
    .rsp (rsp)
  );

endmodule
`default_nettype wire

>>> design/ktp_mem.sv
`timescale 1ns / 1ps
`default_nettype none
module ktp_mem #(
  parameter int NODES  = 1024,
  parameter int LEVELS = 10
) (
  input  wire logic              clk,
  input  wire ktp_pkg::mem_req_t req,
  output ktp_pkg::mem_rsp_t      rsp
);
  import ktp_pkg::*;

  localparam int NW = $clog2(NODES);
  localparam int LW = $clog2(LEVELS);
  localparam int AD = NODES << LW;

  node_t depth_mem [NODES];
  node_t anc_mem   [AD];

  node_t dep_q_r, anc_a_q_r, anc_b_q_r;
  logic  dep_zero_r, a_zero_r, b_zero_r;

  // depth table, one write and one read port
  always_ff @(posedge clk) begin
    if (req.dep_we) begin
      depth_mem[NW'(req.dep_wnode)] <= req.dep_wdata;
    end
    dep_q_r    <= depth_mem[NW'(req.dep_rnode)];
    dep_zero_r <= (req.dep_rnode == '0);
  end

  // ancestor table, one write and two read ports
  always_ff @(posedge clk) begin
    if (req.anc_we) begin
      anc_mem[{NW'(req.anc_wnode), LW'(req.anc_wlvl)}] <= req.anc_wdata;
    end
    anc_a_q_r <= anc_mem[{NW'(req.anc_anode), LW'(req.anc_alvl)}];
    anc_b_q_r <= anc_mem[{NW'(req.anc_bnode), LW'(req.anc_blvl)}];
    a_zero_r  <= (req.anc_anode == '0);
    b_zero_r  <= (req.anc_bnode == '0);
  end

  // node 0 reads as zero everywhere
  assign rsp.dep_rdata = dep_zero_r ? '0 : dep_q_r;
  assign rsp.anc_adata = a_zero_r ? '0 : anc_a_q_r;
  assign rsp.anc_bdata = b_zero_r ? '0 : anc_b_q_r;

endmodule
`default_nettype wire

>>> design/ktp_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module ktp_ctrl #(
  parameter int NODES  = 1024,
  parameter int LEVELS = 10
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire ktp_pkg::in_item_t  in_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output ktp_pkg::out_item_t      out_data,
  output ktp_pkg::mem_req_t       req,
  input  wire ktp_pkg::mem_rsp_t  rsp
);
  import ktp_pkg::*;

  localparam int LW = $clog2(LEVELS);
  localparam logic [LW-1:0] LTOP = LW'(LEVELS - 1);
  localparam logic [16:0] NODES_W = 17'(NODES);

  typedef enum logic [3:0] {
    S_IDLE, S_LD_DEP, S_LD_RD, S_LD_WR, S_Q_DU, S_Q_DV, S_CL_RD, S_CL_WR,
    S_LC_RD, S_LC_CMP, S_LC_TOP, S_LC_TOP2, S_Q_RDL, S_Q_DL, S_OUT
  } state_t;

  typedef enum logic {PH_ALIGN, PH_KTH} phase_t;

  state_t            state_r;
  phase_t            phase_r;
  logic [LW-1:0]     lvl_r;
  node_t             u_r, v_r, nn_r, a_r, b_r, c_r, l_r, du_r, dv_r, res_r;
  step_t             k_r;
  logic signed [12:0] rem_r;
  logic              found_r;
  out_item_t         out_r;
  logic              out_valid_r;

  logic              acc;
  logic              u_ok, v_ok;
  node_t             par_eff;
  logic [16:0]       w_big;
  logic              take;
  node_t             c_fin;
  node_t             dep_inc;
  logic signed [12:0] dul, dvl, tot, ks;

  assign in_ready  = (state_r == S_IDLE);
  assign acc       = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // input checks
  assign u_ok    = (in_data.node != '0) && ({7'b0, in_data.node} < NODES_W);
  assign v_ok    = (in_data.target_node != '0) &&
                   ({7'b0, in_data.target_node} < NODES_W);
  assign par_eff = ({7'b0, in_data.parent_node} < NODES_W) ? in_data.parent_node : '0;

  // binary step decision for the climb
  assign w_big = 17'(1) << lvl_r;
  assign take  = ({4'b0, rem_r} >= w_big);
  assign c_fin = (state_r == S_CL_WR) ? rsp.anc_adata : c_r;

  assign dep_inc = (rsp.dep_rdata == DEPTH_MAX) ? DEPTH_MAX : rsp.dep_rdata + 10'd1;

  // path lengths after the lca depth is known
  assign dul = $signed({3'b0, du_r}) - $signed({3'b0, rsp.dep_rdata});
  assign dvl = $signed({3'b0, dv_r}) - $signed({3'b0, rsp.dep_rdata});
  assign tot = dul + dvl;
  assign ks  = $signed({2'b0, k_r});

  // table requests
  always_comb begin
    req = '0;
    unique case (state_r)
      S_IDLE: begin
        if (acc) begin
          req.dep_rnode = (in_data.action == ACT_LOAD) ? par_eff : in_data.node;
        end
      end
      S_LD_DEP: begin
        req.dep_we    = 1'b1;
        req.dep_wnode = nn_r;
        req.dep_wdata = (c_r == '0) ? '0 : dep_inc;
        req.anc_we    = 1'b1;
        req.anc_wnode = nn_r;
        req.anc_wlvl  = '0;
        req.anc_wdata = c_r;
      end
      S_LD_RD: begin
        req.anc_anode = c_r;
        req.anc_alvl  = lvl_t'(lvl_r - LW'(1));
      end
      S_LD_WR: begin
        req.anc_we    = 1'b1;
        req.anc_wnode = nn_r;
        req.anc_wlvl  = lvl_t'(lvl_r);
        req.anc_wdata = rsp.anc_adata;
      end
      S_Q_DU: req.dep_rnode = v_r;
      S_CL_RD: begin
        req.anc_anode = c_r;
        req.anc_alvl  = lvl_t'(lvl_r);
      end
      S_LC_RD: begin
        req.anc_anode = a_r;
        req.anc_alvl  = lvl_t'(lvl_r);
        req.anc_bnode = b_r;
        req.anc_blvl  = lvl_t'(lvl_r);
      end
      S_LC_TOP: req.anc_anode = a_r;
      S_Q_RDL:  req.dep_rnode = l_r;
      default: ;
    endcase
  end

  // sequencer and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      phase_r     <= PH_ALIGN;
      lvl_r       <= '0;
    end else begin
      // result register drains when taken, unless a new result replaces it
      if (out_valid_r && out_ready && state_r != S_OUT) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (acc) begin
            u_r <= in_data.node;
            v_r <= in_data.target_node;
            k_r <= in_data.step - step_t'(1);
            nn_r <= in_data.node;
            c_r  <= par_eff;
            if (in_data.action == ACT_LOAD) begin
              if (u_ok) state_r <= S_LD_DEP;
            end else if (u_ok && v_ok && in_data.step != '0) begin
              state_r <= S_Q_DU;
            end else begin
              found_r <= 1'b0;
              res_r   <= '0;
              state_r <= S_OUT;
            end
          end
        end
        S_LD_DEP: begin
          lvl_r   <= LW'(1);
          state_r <= S_LD_RD;
        end
        S_LD_RD: state_r <= S_LD_WR;
        S_LD_WR: begin
          c_r <= rsp.anc_adata;
          if (lvl_r == LTOP) begin
            state_r <= S_IDLE;
          end else begin
            lvl_r   <= lvl_r + LW'(1);
            state_r <= S_LD_RD;
          end
        end
        S_Q_DU: begin
          du_r    <= rsp.dep_rdata;
          state_r <= S_Q_DV;
        end
        S_Q_DV: begin
          dv_r    <= rsp.dep_rdata;
          phase_r <= PH_ALIGN;
          lvl_r   <= LTOP;
          state_r <= S_CL_RD;
          if (du_r < rsp.dep_rdata) begin
            c_r   <= v_r;
            b_r   <= u_r;
            rem_r <= 13'(rsp.dep_rdata - du_r);
          end else begin
            c_r   <= u_r;
            b_r   <= v_r;
            rem_r <= 13'(du_r - rsp.dep_rdata);
          end
        end
        S_CL_RD, S_CL_WR: begin
          if (state_r == S_CL_RD && take) begin
            state_r <= S_CL_WR;
          end else begin
            if (state_r == S_CL_WR) begin
              c_r   <= rsp.anc_adata;
              rem_r <= rem_r - $signed(13'(w_big));
            end
            if (lvl_r != '0) begin
              lvl_r   <= lvl_r - LW'(1);
              state_r <= S_CL_RD;
            end else if (phase_r == PH_KTH) begin
              found_r <= 1'b1;
              res_r   <= c_fin;
              state_r <= S_OUT;
            end else begin
              a_r <= c_fin;
              if (c_fin == b_r) begin
                l_r     <= c_fin;
                state_r <= S_Q_RDL;
              end else begin
                lvl_r   <= LTOP;
                state_r <= S_LC_RD;
              end
            end
          end
        end
        S_LC_RD: state_r <= S_LC_CMP;
        S_LC_CMP: begin
          if (rsp.anc_adata != rsp.anc_bdata) begin
            a_r <= rsp.anc_adata;
            b_r <= rsp.anc_bdata;
          end
          if (lvl_r == '0) begin
            state_r <= S_LC_TOP;
          end else begin
            lvl_r   <= lvl_r - LW'(1);
            state_r <= S_LC_RD;
          end
        end
        S_LC_TOP: state_r <= S_LC_TOP2;
        S_LC_TOP2: begin
          l_r     <= rsp.anc_adata;
          state_r <= S_Q_RDL;
        end
        S_Q_RDL: state_r <= S_Q_DL;
        S_Q_DL: begin
          if (ks > tot) begin
            found_r <= 1'b0;
            res_r   <= '0;
            state_r <= S_OUT;
          end else begin
            phase_r <= PH_KTH;
            lvl_r   <= LTOP;
            state_r <= S_CL_RD;
            if (ks <= dul) begin
              c_r   <= u_r;
              rem_r <= ks;
            end else begin
              c_r   <= v_r;
              rem_r <= tot - ks;
            end
          end
        end
        S_OUT: begin
          if (!out_valid_r || out_ready) begin
            out_r       <= '{found: found_r, result_node: res_r};
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // tables are only written while a load transaction runs
  a_wr_only_load: assert property (@(posedge clk) disable iff (!rst_n)
    (req.dep_we || req.anc_we) |-> (state_r == S_LD_DEP || state_r == S_LD_WR))
    else $error("table write outside a load");

  // a load never produces a result
  a_load_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && in_data.action == ACT_LOAD && !out_valid_r) |=> !out_valid_r)
    else $error("load produced a result");

  // a held result is never overwritten
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |=> (out_valid_r && $stable(out_r)))
    else $error("pending result lost");

  // level counter stays inside the table row
  a_lvl_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> (lvl_r <= LTOP))
    else $error("level index out of range");

endmodule
`default_nettype wire
